/* sv/nibble_ring_digit_log_core_assert.svh */
// Assertion macros for the nibble ring digit log core.
`ifndef NIBBLE_RING_DIGIT_LOG_CORE_ASSERT_SVH
`define NIBBLE_RING_DIGIT_LOG_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NRDL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nibble ring digit log assertion failed");
`define NRDL_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("nibble ring digit log assertion failed");
`else
`define NRDL_ASSERT(lbl, prop)
`define NRDL_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

/* sv/nrdl_pkg.sv */
// Package with types, constants and the display character function of the digit log.
package nrdl_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 256;

  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_READ   = 1'b1;
  localparam logic [3:0] END_MARK  = 4'hF;

  localparam logic [3:0] NIB_ZERO  = 4'hA;
  localparam logic [3:0] NIB_STAR  = 4'hB;
  localparam logic [3:0] NIB_HASH  = 4'hC;

  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_STAR  = 7'h2A;
  localparam logic [6:0] CHAR_HASH  = 7'h23;
  localparam logic [2:0] CHAR_DIGIT_HI = 3'b011;

  typedef struct packed {
    logic       op;
    logic [3:0] digit;
    logic [7:0] back_index;
  } cmd_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic [3:0] nibble;
    logic [7:0] marker_pos;
  } result_t;

  function automatic logic [6:0] nib_to_char(input logic [3:0] v);
    logic [6:0] c;
    case (v)
      END_MARK: c = CHAR_SPACE;
      NIB_ZERO: c = CHAR_ZERO;
      NIB_STAR: c = CHAR_STAR;
      NIB_HASH: c = CHAR_HASH;
      default:  c = {CHAR_DIGIT_HI, v};
    endcase
    return c;
  endfunction

endpackage

/* sv/nibble_ring_digit_log_core.sv */
// Top level of the nibble ring digit log: sequencer, wrap unit and packed byte store.
//
// A command is taken when start is high and busy is low; its single result
// appears on result_o for exactly one cycle with done_o high, and the receiver
// cannot stall it. After reset the block first sweeps the byte store to 0xFF,
// one byte per cycle, which keeps busy high until the last byte is written.
// All work goes through one store port and one compare-and-subtract wrap unit.
// A read passes ST_WRAP, with one extra step per subtraction of SLOT_COUNT
// needed to wrap marker+1+back_index (one at most when SLOT_COUNT is 256),
// then ST_RD and ST_MERGE; the result shows in the cycle after ST_MERGE. An
// append is two read-modify-write byte accesses plus one wrap of the slot.
module nibble_ring_digit_log_core #(
  parameter int unsigned SLOT_COUNT = nrdl_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  nrdl_pkg::cmd_t   cmd_i,
  output logic             done_o,
  output nrdl_pkg::result_t result_o
);
  import nrdl_pkg::*;

  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned ADDR_W     = SLOT_W - 1;
  localparam int unsigned BYTE_COUNT = (SLOT_COUNT + 1) / 2;
  localparam int unsigned SUM_W      = $clog2(SLOT_COUNT + 256);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WRAP  = 5'b00100,
    ST_RD    = 5'b01000,
    ST_MERGE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_addr_q, clr_addr_d;
  logic [SLOT_W-1:0]   marker_q, marker_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic                phase_q, phase_d;
  logic                op_q, op_d;
  logic [3:0]          digit_q, digit_d;
  logic [7:0]          rdata_q;
  logic                done_q, done_d;
  result_t             result_q, result_d;

  logic [7:0]          mem [BYTE_COUNT];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [7:0]          mem_wdata;

  logic [3:0]          rd_nib;
  logic [3:0]          wr_nib;
  logic [7:0]          merged;
  logic [SLOT_W+7:0]   slot_ext;
  logic [SLOT_W+7:0]   marker_ext;

  assign rd_nib     = slot_q[0] ? rdata_q[3:0] : rdata_q[7:4];
  assign wr_nib     = phase_q ? END_MARK : digit_q;
  assign merged     = slot_q[0] ? {rdata_q[7:4], wr_nib} : {wr_nib, rdata_q[3:0]};
  assign slot_ext   = {8'd0, slot_q};
  assign marker_ext = {8'd0, marker_q};

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    marker_d   = marker_q;
    slot_d     = slot_q;
    acc_d      = acc_q;
    phase_d    = phase_q;
    op_d       = op_q;
    digit_d    = digit_q;
    done_d     = 1'b0;
    result_d   = result_q;
    mem_we     = 1'b0;
    mem_addr   = slot_q[SLOT_W-1:1];
    mem_wdata  = merged;
    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_addr   = clr_addr_q;
        mem_wdata  = 8'hFF;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(BYTE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_d    = cmd_i.op;
          digit_d = cmd_i.digit;
          phase_d = 1'b0;
          if (cmd_i.op == OP_APPEND) begin
            slot_d  = marker_q;
            state_d = ST_RD;
          end else begin
            acc_d   = SUM_W'(marker_q) + SUM_W'(cmd_i.back_index) + SUM_W'(1);
            state_d = ST_WRAP;
          end
        end
      end
      ST_WRAP: begin
        if (acc_q >= SUM_W'(SLOT_COUNT)) begin
          acc_d = acc_q - SUM_W'(SLOT_COUNT);
        end else begin
          slot_d  = acc_q[SLOT_W-1:0];
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (op_q == OP_READ) begin
          result_d.nibble     = rd_nib;
          result_d.ascii_char = nib_to_char(rd_nib);
          result_d.marker_pos = marker_ext[7:0];
          done_d              = 1'b1;
          state_d             = ST_IDLE;
        end else if (!phase_q) begin
          mem_we  = 1'b1;
          phase_d = 1'b1;
          acc_d   = SUM_W'(slot_q) + SUM_W'(1);
          state_d = ST_WRAP;
        end else begin
          mem_we              = 1'b1;
          marker_d            = slot_q;
          result_d.nibble     = digit_q;
          result_d.ascii_char = nib_to_char(digit_q);
          result_d.marker_pos = slot_ext[7:0];
          done_d              = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      marker_q   <= '0;
      phase_q    <= 1'b0;
      op_q       <= OP_APPEND;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      marker_q   <= marker_d;
      phase_q    <= phase_d;
      op_q       <= op_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    acc_q    <= acc_d;
    digit_q  <= digit_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (state_q == ST_RD) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

`include "nibble_ring_digit_log_core_assert.svh"

  `NRDL_ASSERT(a_done_when_idle, !done_q || !busy)
  `NRDL_ASSERT_IMPL(a_accept_goes_busy, start && !busy, busy)
  `NRDL_ASSERT(a_marker_moves_on_done, done_q || $stable(marker_q))
  `NRDL_ASSERT(a_result_marker, !done_q || (result_q.marker_pos == marker_ext[7:0]))

endmodule

/* verif/tb_nibble_ring_digit_log_core.sv */
// Self-checking testbench for the nibble ring digit log core with a built-in log predictor.
module tb_nibble_ring_digit_log_core;
  import nrdl_pkg::*;

  localparam int unsigned SLOTS        = SLOT_COUNT_DEF;
  localparam int unsigned BYTES        = (SLOTS + 1) / 2;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CALM_FIRST   = 700;
  localparam int unsigned CALM_LAST    = 1000;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  cmd_t    cmd_i  = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  cmd_t    cmd_backlog[$];
  result_t pending_readouts[$];
  logic [7:0]  model_bytes [BYTES];
  int unsigned model_marker;

  logic taken = 1'b0;
  int unsigned cycle_cnt    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned append_cnt   = 0;
  int unsigned read_cnt     = 0;
  int unsigned checked_cnt  = 0;
  int unsigned error_cnt    = 0;

  nibble_ring_digit_log_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [3:0] log_nibble_at(input int unsigned slot);
    logic [7:0] b;
    b = model_bytes[slot / 2];
    return slot[0] ? b[3:0] : b[7:4];
  endfunction

  function automatic void log_nibble_put(input int unsigned slot, input logic [3:0] v);
    if (slot[0]) begin
      model_bytes[slot / 2][3:0] = v;
    end else begin
      model_bytes[slot / 2][7:4] = v;
    end
  endfunction

  function automatic logic [6:0] keypad_char(input logic [3:0] v);
    if (v == END_MARK) return CHAR_SPACE;
    if (v == NIB_ZERO) return CHAR_ZERO;
    if (v == NIB_STAR) return CHAR_STAR;
    if (v == NIB_HASH) return CHAR_HASH;
    return CHAR_ZERO | {3'b000, v};
  endfunction

  function automatic result_t log_model_apply(input cmd_t c);
    result_t r;
    logic [3:0] v;
    if (c.op == OP_APPEND) begin
      log_nibble_put(model_marker, c.digit);
      model_marker = (model_marker + 1) % SLOTS;
      log_nibble_put(model_marker, END_MARK);
      v = c.digit;
    end else begin
      v = log_nibble_at((model_marker + 1 + c.back_index) % SLOTS);
    end
    r.ascii_char = keypad_char(v);
    r.nibble     = v;
    r.marker_pos = model_marker[7:0];
    return r;
  endfunction

  function automatic void field_check(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      error_cnt++;
    end
  endfunction

  function automatic void queue_cmd(input logic op, input logic [3:0] dig,
                                    input logic [7:0] back);
    cmd_t c;
    c.op         = op;
    c.digit      = dig;
    c.back_index = back;
    cmd_backlog.push_back(c);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!start || taken)) begin
      if (cmd_backlog.size() != 0 &&
          ((accepted_cnt >= CALM_FIRST && accepted_cnt < CALM_LAST) ||
           $urandom_range(99) >= 32)) begin
        cmd_i <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        cmd_i <= cmd_t'($urandom);
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_readouts.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual 0x%0h", $time, result_o);
          error_cnt++;
        end else begin
          want = pending_readouts.pop_front();
          field_check("ascii_char", want.ascii_char, result_o.ascii_char);
          field_check("nibble", want.nibble, result_o.nibble);
          field_check("marker_pos", want.marker_pos, result_o.marker_pos);
          checked_cnt++;
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        pending_readouts.push_back(log_model_apply(cmd_i));
        accepted_cnt++;
        if (cmd_i.op == OP_APPEND) append_cnt++;
        else read_cnt++;
      end
    end else begin
      taken <= 1'b0;
    end
  end

  initial begin
    logic       op;
    logic [7:0] back;
    foreach (model_bytes[i]) model_bytes[i] = 8'hFF;
    model_marker = 0;

    // Every digit code, the end marker included, then reads at the edges of the ring.
    for (int d = 0; d < 16; d++) begin
      queue_cmd(OP_APPEND, 4'(d), 8'(d * 17));
    end
    queue_cmd(OP_READ, 4'h0, 8'd0);
    queue_cmd(OP_READ, 4'hF, 8'd254);
    queue_cmd(OP_READ, 4'h5, 8'd255);
    queue_cmd(OP_READ, 4'hA, 8'd253);
    queue_cmd(OP_READ, 4'h3, 8'd240);
    queue_cmd(OP_READ, 4'hC, 8'd127);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      op = ($urandom_range(99) < 55) ? OP_APPEND : OP_READ;
      back = ($urandom_range(99) < 30) ? 8'($urandom_range(255, 230)) : 8'($urandom);
      queue_cmd(op, 4'($urandom), back);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start) @(posedge clk_i);
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d appends and %0d reads; the marker wrapped the ring %0d times.",
             append_cnt, read_cnt, append_cnt / SLOTS);
    $display("Checked %0d results, %0d field errors.", checked_cnt, error_cnt);
    if (error_cnt == 0 && pending_readouts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/nrdl_pkg.sv
sv/nibble_ring_digit_log_core.sv
verif/tb_nibble_ring_digit_log_core.sv
